/* rtl/utbd_pkg.sv */
// Shared types and constants for the unsigned to base digits converter.
// No dependencies; used by every module of the block.
`default_nettype none

package utbd_pkg;

  localparam int VALUE_BITS_DEF     = 64;
  localparam int MAX_RADIX_DEF      = 16;
  localparam int MAX_DIGITS_DEF     = 64;
  localparam int ITEM_QUEUE_DEPTH   = 2;
  localparam int RESULT_QUEUE_DEPTH = 2;

  localparam int RADIX_BITS     = 5;
  localparam int CHAR_BITS      = 8;
  localparam int DIGIT_BITS     = 4;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 64;
  localparam int TABLE_BITS     = 2 * CFG_DATA_BITS;

  localparam logic [CHAR_BITS-1:0]  SPACE_CHAR = 8'h20;
  localparam logic [RADIX_BITS-1:0] MIN_RADIX  = 5'd2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DIGIT_CHARS_LOW  = 1'b0,
    CFG_DIGIT_CHARS_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    K_CONVERT    = 2'd0,
    K_ZERO_SPACE = 2'd1,
    K_ZERO_TABLE = 2'd2,
    K_ERROR      = 2'd3
  } kind_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] character;
    logic                 last;
    logic                 error;
  } res_t;

endpackage

`default_nettype wire

/* rtl/utbd_fifo.sv */
// Small register queue used between the front and back, and on the result side.
// Depends on utbd_pkg for default sizes.
`default_nettype none

module utbd_fifo #(
  parameter int WIDTH = $bits(utbd_pkg::res_t),
  parameter int DEPTH = utbd_pkg::RESULT_QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/utbd_front.sv */
// Input side: accepts items, classifies them and queues them for the back end.
// Depends on utbd_pkg and utbd_fifo.
`default_nettype none

module utbd_front #(
  parameter int VALUE_BITS = utbd_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = utbd_pkg::MAX_RADIX_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [VALUE_BITS-1:0]           value,
  input  wire logic [utbd_pkg::RADIX_BITS-1:0] radix,
  input  wire logic                            precision_given,
  input  wire logic                            item_pop,
  output logic                                 item_empty,
  output logic      [VALUE_BITS-1:0]           item_value,
  output logic      [utbd_pkg::RADIX_BITS-1:0] item_radix,
  output utbd_pkg::kind_t                      item_kind
);

  localparam int WORD_BITS = VALUE_BITS + utbd_pkg::RADIX_BITS + 2;

  utbd_pkg::kind_t  kind;
  logic [WORD_BITS-1:0] wr_word;
  logic [WORD_BITS-1:0] rd_word;

  always_comb begin
    if (radix < utbd_pkg::MIN_RADIX || radix > utbd_pkg::RADIX_BITS'(MAX_RADIX)) begin
      kind = utbd_pkg::K_ERROR;
    end else if (value == '0) begin
      kind = precision_given ? utbd_pkg::K_ZERO_TABLE : utbd_pkg::K_ZERO_SPACE;
    end else begin
      kind = utbd_pkg::K_CONVERT;
    end
  end

  assign wr_word = {value, radix, kind};

  utbd_fifo #(
    .WIDTH(WORD_BITS),
    .DEPTH(utbd_pkg::ITEM_QUEUE_DEPTH)
  ) u_item_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .wr_data (wr_word),
    .pop     (item_pop),
    .empty   (item_empty),
    .rd_data (rd_word)
  );

  assign item_value = rd_word[WORD_BITS-1 -: VALUE_BITS];
  assign item_radix = rd_word[2 +: utbd_pkg::RADIX_BITS];
  assign item_kind  = utbd_pkg::kind_t'(rd_word[1:0]);

endmodule

`default_nettype wire

/* rtl/utbd_back.sv */
// Back end: byte-serial division by the radix, digit stack, and digit emission.
// Depends on utbd_pkg.
`default_nettype none

module utbd_back #(
  parameter int VALUE_BITS = utbd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = utbd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [utbd_pkg::TABLE_BITS-1:0] digit_table,
  input  wire logic                            item_empty,
  output logic                                 item_pop,
  input  wire logic [VALUE_BITS-1:0]           item_value,
  input  wire logic [utbd_pkg::RADIX_BITS-1:0] item_radix,
  input  wire utbd_pkg::kind_t                 item_kind,
  input  wire logic                            res_full,
  output logic                                 res_push,
  output utbd_pkg::res_t                       res_data
);

  localparam int NB       = (VALUE_BITS + 7) / 8;
  localparam int PAD_BITS = NB * 8;
  localparam int BI_W     = (NB > 1) ? $clog2(NB) : 1;
  localparam int SA_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int RB       = utbd_pkg::RADIX_BITS;
  localparam int DB       = utbd_pkg::DIGIT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_DIV,
    S_EMIT_RD,
    S_EMIT_WR
  } state_t;

  state_t                state;
  logic [PAD_BITS-1:0]   rv;
  logic [RB-1:0]         rad;
  utbd_pkg::kind_t       kind_r;
  logic [BI_W-1:0]       top;
  logic [BI_W-1:0]       bidx;
  logic [RB-1:0]         rem;
  logic [CNT_W-1:0]      count;
  logic [SA_W-1:0]       eidx;
  logic [DB-1:0]         stack [MAX_DIGITS];
  logic [DB-1:0]         rd_digit;

  logic [PAD_BITS-1:0]   in_pad;
  logic [BI_W-1:0]       first_top;
  logic [7:0]            chunk;
  logic [7:0]            qbyte;
  logic [RB-1:0]         rem_out;
  logic [RB-1:0]         r;
  logic [RB-1:0]         t;
  logic [PAD_BITS-1:0]   rv_q;
  logic                  top_drop;
  logic                  stack_we;

  assign in_pad = PAD_BITS'(item_value);

  always_comb begin
    first_top = '0;
    for (int i = 0; i < NB; i++) begin
      if (in_pad[i*8 +: 8] != 8'd0) begin
        first_top = BI_W'(i);
      end
    end
  end

  // eight restoring steps on one dividend byte
  assign chunk = rv[bidx*8 +: 8];

  always_comb begin
    r     = rem;
    t     = '0;
    qbyte = '0;
    for (int j = 7; j >= 0; j--) begin
      t = {r[RB-2:0], chunk[j]};
      if (t >= rad) begin
        qbyte[j] = 1'b1;
        r        = t - rad;
      end else begin
        r = t;
      end
    end
    rem_out = r;
  end

  always_comb begin
    rv_q = rv;
    rv_q[bidx*8 +: 8] = qbyte;
  end

  assign top_drop = (top != '0) && (rv_q[top*8 +: 8] == 8'd0);
  assign stack_we = (state == S_DIV) && (bidx == '0);
  assign item_pop = (state == S_IDLE) && !item_empty;

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack[count[SA_W-1:0]] <= rem_out[DB-1:0];
    end
    rd_digit <= stack[eidx];
  end

  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    case (state)
      S_SINGLE: begin
        res_push      = !res_full;
        res_data.last = 1'b1;
        case (kind_r)
          utbd_pkg::K_ERROR: begin
            res_data.error = 1'b1;
          end
          utbd_pkg::K_ZERO_TABLE: begin
            res_data.character = digit_table[7:0];
          end
          default: begin
            res_data.character = utbd_pkg::SPACE_CHAR;
          end
        endcase
      end
      S_EMIT_WR: begin
        res_push           = !res_full;
        res_data.character = digit_table[rd_digit*8 +: 8];
        res_data.last      = (eidx == '0);
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!item_empty) begin
            rv     <= in_pad;
            rad    <= item_radix;
            kind_r <= item_kind;
            count  <= '0;
            rem    <= '0;
            top    <= first_top;
            bidx   <= first_top;
            state  <= (item_kind == utbd_pkg::K_CONVERT) ? S_DIV : S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          rv <= rv_q;
          if (bidx == '0) begin
            rem   <= '0;
            count <= count + 1'b1;
            if (top_drop) begin
              top  <= top - 1'b1;
              bidx <= top - 1'b1;
            end else begin
              bidx <= top;
            end
            if (rv_q == '0 || count == CNT_W'(MAX_DIGITS - 1)) begin
              eidx  <= count[SA_W-1:0];
              state <= S_EMIT_RD;
            end
          end else begin
            rem  <= rem_out;
            bidx <= bidx - 1'b1;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WR;
        end
        S_EMIT_WR: begin
          if (!res_full) begin
            if (eidx == '0) begin
              state <= S_IDLE;
            end else begin
              eidx  <= eidx - 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/unsigned_to_base_digits.sv */
// Top level of the unsigned to base digits converter: config registers and wiring.
// Depends on utbd_pkg, utbd_fifo, utbd_front, utbd_back.
//
// channel   direction  handshake                 payload
// input     in         push / full               value, radix, precision_given
// result    out        empty / pop               character, last, error
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Conversion: load the item, then for each digit divide the active value bytes
// one at a time (8 down to 1 as the quotient shrinks), then read each digit from
// the stack and write its character to the result queue. Zero value or bad radix:
// a single result character. The byte-serial divider is in the back end.
// rst is synchronous; the digit stack is not cleared. A full result queue stalls
// emission only; the front keeps taking items until its queue fills.
`default_nettype none

module unsigned_to_base_digits #(
  parameter int VALUE_BITS = utbd_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = utbd_pkg::MAX_RADIX_DEF,
  parameter int MAX_DIGITS = utbd_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic [VALUE_BITS-1:0]               value,
  input  wire logic [utbd_pkg::RADIX_BITS-1:0]     radix,
  input  wire logic                                precision_given,
  output logic                                     empty,
  input  wire logic                                pop,
  output logic      [utbd_pkg::CHAR_BITS-1:0]      character,
  output logic                                     last,
  output logic                                     error,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [utbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [utbd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic [utbd_pkg::CFG_DATA_BITS-1:0] digit_chars_low;
  logic [utbd_pkg::CFG_DATA_BITS-1:0] digit_chars_high;

  logic                                item_pop;
  logic                                item_empty;
  logic [VALUE_BITS-1:0]               item_value;
  logic [utbd_pkg::RADIX_BITS-1:0]     item_radix;
  utbd_pkg::kind_t                     item_kind;
  logic                                res_full;
  logic                                res_push;
  utbd_pkg::res_t                      res_in;
  utbd_pkg::res_t                      res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_chars_low  <= '0;
      digit_chars_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (utbd_pkg::cfg_reg_t'(cfg_index))
        utbd_pkg::CFG_DIGIT_CHARS_LOW:  digit_chars_low  <= cfg_data;
        utbd_pkg::CFG_DIGIT_CHARS_HIGH: digit_chars_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  utbd_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_RADIX (MAX_RADIX)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .value           (value),
    .radix           (radix),
    .precision_given (precision_given),
    .item_pop        (item_pop),
    .item_empty      (item_empty),
    .item_value      (item_value),
    .item_radix      (item_radix),
    .item_kind       (item_kind)
  );

  utbd_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .digit_table ({digit_chars_high, digit_chars_low}),
    .item_empty  (item_empty),
    .item_pop    (item_pop),
    .item_value  (item_value),
    .item_radix  (item_radix),
    .item_kind   (item_kind),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_in)
  );

  utbd_fifo #(
    .WIDTH($bits(utbd_pkg::res_t)),
    .DEPTH(utbd_pkg::RESULT_QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .wr_data (res_in),
    .pop     (pop),
    .empty   (empty),
    .rd_data (res_out)
  );

  assign character = res_out.character;
  assign last      = res_out.last;
  assign error     = res_out.error;

  // error transaction is a single zero character
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (!empty && error) |-> (character == '0 && last))
    else $error("error result not a lone zero character");

  a_item_queued: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !item_empty)
    else $error("accepted item missing from item queue");

  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> empty)
    else $error("result queue not empty after reset");

endmodule

`default_nettype wire

/* tb/sv/utbd_digit_checker.sv */
// Checker for the unsigned to base digits converter: watches the input, config and
// result channels, predicts the digit characters and compares them.
// Depends on utbd_pkg.
module utbd_digit_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic [utbd_pkg::VALUE_BITS_DEF-1:0] value,
  input  logic [utbd_pkg::RADIX_BITS-1:0]     radix,
  input  logic                                precision_given,
  input  logic                                empty,
  input  logic                                pop,
  input  logic [utbd_pkg::CHAR_BITS-1:0]      character,
  input  logic                                last,
  input  logic                                error,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [utbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [utbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import utbd_pkg::*;

  logic [TABLE_BITS-1:0] digit_table;
  res_t                  char_queue[$];

  function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d);
    return digit_table[CHAR_BITS*d +: CHAR_BITS];
  endfunction

  function automatic void queue_conversion(input logic [VALUE_BITS_DEF-1:0] num,
                                           input logic [RADIX_BITS-1:0] base,
                                           input logic zero_glyph);
    logic [VALUE_BITS_DEF-1:0] rest;
    logic [VALUE_BITS_DEF-1:0] base_wide;
    logic [DIGIT_BITS-1:0]     digits[MAX_DIGITS_DEF];
    int                        n;
    res_t                      r;
    if (base < MIN_RADIX || int'(base) > MAX_RADIX_DEF) begin
      r.character = '0;
      r.last      = 1'b1;
      r.error     = 1'b1;
      char_queue.push_back(r);
      return;
    end
    rest = num;
    r.error = 1'b0;
    if (rest == 0) begin
      r.character = zero_glyph ? glyph('0) : SPACE_CHAR;
      r.last      = 1'b1;
      char_queue.push_back(r);
      return;
    end
    base_wide = VALUE_BITS_DEF'(base);
    n = 0;
    while (rest != 0 && n < MAX_DIGITS_DEF) begin
      digits[n] = DIGIT_BITS'(rest % base_wide);
      rest      = rest / base_wide;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      r.character = glyph(digits[k]);
      r.last      = (k == 0);
      char_queue.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      char_queue.delete();
      digit_table = '0;
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DIGIT_CHARS_LOW:  digit_table[CFG_DATA_BITS-1:0] = cfg_data;
          CFG_DIGIT_CHARS_HIGH: digit_table[TABLE_BITS-1:CFG_DATA_BITS] = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        queue_conversion(value, radix, precision_given);
      if (pop && !empty) begin
        if (char_queue.size() == 0) begin
          $display("%0t: unexpected result transaction char=%h last=%b error=%b",
                   $realtime, character, last, error);
          fail_count++;
        end else begin
          want = char_queue.pop_front();
          if (character !== want.character) begin
            $display("%0t: character expected %h actual %h", $realtime,
                     want.character, character);
            fail_count++;
          end
          if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $realtime, want.last, last);
            fail_count++;
          end
          if (error !== want.error) begin
            $display("%0t: error expected %b actual %b", $realtime, want.error, error);
            fail_count++;
          end
        end
      end
    end
    outstanding <= char_queue.size();
  end

endmodule

/* tb/sv/tb_unsigned_to_base_digits.sv */
// Testbench top for the unsigned to base digits converter: clock, reset, stimulus
// and verdict. Depends on utbd_pkg, unsigned_to_base_digits and utbd_digit_checker.
module tb_unsigned_to_base_digits;
  timeunit 1ns;
  timeprecision 1ps;
  import utbd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HEX_LOW    = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HIGH   = 64'h6665_6463_6261_3938;
  localparam logic [63:0] UPPER_HIGH = 64'h4645_4443_4241_3938;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      push = 1'b0;
  logic                      full;
  logic [VALUE_BITS_DEF-1:0] value = '0;
  logic [RADIX_BITS-1:0]     radix = '0;
  logic                      precision_given = 1'b0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [CHAR_BITS-1:0]      character;
  logic                      last;
  logic                      error;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int hold_requests = 0;
  bit gaps_on = 1'b1;
  int burst_left = 1;

  unsigned_to_base_digits DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .value(value), .radix(radix), .precision_given(precision_given),
    .empty(empty), .pop(pop),
    .character(character), .last(last), .error(error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  utbd_digit_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .value(value), .radix(radix), .precision_given(precision_given),
    .empty(empty), .pop(pop),
    .character(character), .last(last), .error(error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: stall pattern redrawn at random from four modes; long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int hold_served;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = 50;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_table_reg(input cfg_reg_t idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_table(input logic [63:0] lo, input logic [63:0] hi);
    write_table_reg(CFG_DIGIT_CHARS_LOW, lo);
    write_table_reg(CFG_DIGIT_CHARS_HIGH, hi);
  endtask

  task automatic send_conversion(input logic [63:0] v, input logic [4:0] r, input logic p);
    push            <= 1'b1;
    value           <= v;
    radix           <= r;
    precision_given <= p;
    do @(posedge clk); while (full);
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_random_conversion;
    logic [63:0] v;
    logic [4:0]  r;
    int          bits;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = 64'($urandom_range(0, 255));
      default: begin
        bits = $urandom_range(1, 64);
        v = {$urandom, $urandom} >> (64 - bits);
      end
    endcase
    if ($urandom_range(0, 9) == 0) r = 5'($urandom_range(0, 31));
    else r = 5'($urandom_range(2, 16));
    send_conversion(v, r, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset table: all glyphs zero
    gaps_on = 1'b0;
    send_conversion('0, 5'd10, 1'b1);
    send_conversion(64'd255, 5'd16, 1'b0);
    send_conversion('0, 5'd10, 1'b0);
    drain();

    load_table(HEX_LOW, HEX_HIGH);
    gaps_on = 1'b1;
    send_conversion('0, 5'd10, 1'b0);
    send_conversion('0, 5'd16, 1'b1);
    send_conversion(64'd1, 5'd2, 1'b0);
    send_conversion(ALL_ONES, 5'd2, 1'b0);
    send_conversion(ALL_ONES, 5'd16, 1'b1);
    send_conversion(ALL_ONES, 5'd10, 1'b0);
    send_conversion(ALL_ONES, 5'd3, 1'b1);
    send_conversion(64'h8000_0000_0000_0000, 5'd2, 1'b1);
    send_conversion(64'd255, 5'd16, 1'b0);
    send_conversion(64'd15, 5'd16, 1'b0);
    send_conversion(64'd16, 5'd16, 1'b1);
    send_conversion(64'd12345, 5'd10, 1'b0);
    send_conversion(64'd7, 5'd8, 1'b0);
    send_conversion(64'd5, 5'd15, 1'b0);
    send_conversion(64'd100, 5'd9, 1'b1);
    send_conversion(64'h0123_4567_89AB_CDEF, 5'd0, 1'b0);
    send_conversion(ALL_ONES, 5'd1, 1'b1);
    send_conversion(64'd42, 5'd17, 1'b0);
    send_conversion(64'd42, 5'd31, 1'b1);
    send_conversion('0, 5'd0, 1'b0);
    send_conversion('0, 5'd1, 1'b1);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: load_table(ALL_ONES, ALL_ONES);
        1: load_table(HEX_LOW, UPPER_HIGH);
        default: load_table({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      gaps_on = (phase != 1);
      burst_left = $urandom_range(1, 8);
      for (int i = 0; i < 39; i++) begin
        if (phase == 2 && i == 10) hold_requests++;
        send_random_conversion();
      end
      drain();
    end

    load_table('0, '0);
    send_conversion('0, 5'd16, 1'b1);
    send_conversion(64'd200, 5'd7, 1'b0);
    drain();
    repeat (50) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
